[rtl/fbhp_pkg.sv]
// shared types, constants and cpu code lookup for the fat header parser
`timescale 1ns / 1ps

package fbhp_pkg;

  localparam logic [31:0] FAT_MAGIC = 32'hcafebabe;
  localparam logic [31:0] ABI64_BIT = 32'h01000000;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned ENTRY_BYTES = 20;
  localparam int unsigned SIZE_W = 40;
  localparam int unsigned POS_W = 5;

  // result status codes
  typedef enum logic [2:0] {
    ST_SLICE_OK     = 3'd0,
    ST_BAD_MAGIC    = 3'd1,
    ST_BAD_COUNT    = 3'd2,
    ST_TOO_SMALL    = 3'd3,
    ST_OUT_OF_BOUND = 3'd4
  } status_t;

  // cpu codes
  localparam logic [3:0] CPU_UNKNOWN = 4'd0;
  localparam logic [3:0] CPU_X86     = 4'd1;
  localparam logic [3:0] CPU_X86_64  = 4'd2;
  localparam logic [3:0] CPU_ARM     = 4'd3;
  localparam logic [3:0] CPU_ARM64   = 4'd4;
  localparam logic [3:0] CPU_PPC     = 4'd5;
  localparam logic [3:0] CPU_PPC64   = 4'd6;
  localparam logic [3:0] CPU_M68K    = 4'd7;
  localparam logic [3:0] CPU_M88K    = 4'd8;
  localparam logic [3:0] CPU_M98K    = 4'd9;
  localparam logic [3:0] CPU_SPARC   = 4'd10;
  localparam logic [3:0] CPU_MIPS    = 4'd11;
  localparam logic [3:0] CPU_HPPA    = 4'd12;
  localparam logic [3:0] CPU_I860    = 4'd13;
  localparam logic [3:0] CPU_VAX     = 4'd14;

  // one accepted input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_word_t;

  // one result word
  typedef struct packed {
    status_t     status;
    logic [4:0]  slice_index;
    logic [31:0] cpu_type;
    logic [31:0] cpu_subtype;
    logic [31:0] slice_offset;
    logic [31:0] slice_size;
    logic [3:0]  cpu_code;
    logic        is_64bit;
    logic        last;
  } result_t;

  // map a raw cpu type word to its code
  function automatic logic [3:0] cpu_code_of(input logic [31:0] t);
    logic [3:0] code;
    case (t)
      32'd7:              code = CPU_X86;
      32'd7 | ABI64_BIT:  code = CPU_X86_64;
      32'd12:             code = CPU_ARM;
      32'd12 | ABI64_BIT: code = CPU_ARM64;
      32'd18:             code = CPU_PPC;
      32'd18 | ABI64_BIT: code = CPU_PPC64;
      32'd6:              code = CPU_M68K;
      32'd13:             code = CPU_M88K;
      32'd10:             code = CPU_M98K;
      32'd14:             code = CPU_SPARC;
      32'd8:              code = CPU_MIPS;
      32'd11:             code = CPU_HPPA;
      32'd15:             code = CPU_I860;
      32'd1:              code = CPU_VAX;
      default:            code = CPU_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

[rtl/fbhp_in_reg.sv]
// input register stage holding one stream word for the parser
`timescale 1ns / 1ps

module fbhp_in_reg
  import fbhp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  input  logic     take,
  output logic     held_valid,
  output in_word_t held_word
);

  // free when empty or when the held word leaves this cycle
  assign in_ready = !held_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_word <= in_word;
    end
  end

endmodule

[rtl/fbhp_parser.sv]
// header and slice table parser state with per-byte decode logic
`timescale 1ns / 1ps

module fbhp_parser
  import fbhp_pkg::*;
#(
  parameter int unsigned MAX_SLICES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              held_valid,
  input  in_word_t          held_word,
  input  logic              queue_full,
  output logic              take,
  output logic              emit,
  output result_t           result
);

  localparam int unsigned CNT_W = $clog2(MAX_SLICES + 1);
  localparam int unsigned IDX_W = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_TABLE  = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  logic [SIZE_W-1:0] image_size;
  phase_t            phase, phase_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [31:0]       shift_word, shift_word_next;
  logic [CNT_W-1:0]  slice_count, slice_count_next;
  logic [IDX_W-1:0]  entry_index, entry_index_next;
  logic [31:0]       held_cpu_type, held_cpu_type_next;
  logic [31:0]       held_subtype, held_subtype_next;
  logic [31:0]       held_offset, held_offset_next;
  logic [31:0]       held_size, held_size_next;

  logic [POS_W-1:0]  pos_cur;
  logic [31:0]       shifted;
  logic [CNT_W-1:0]  count_short;
  logic [SIZE_W-1:0] table_need;
  logic [32:0]       span_end;
  logic              bad_bounds;
  logic              final_entry;
  logic [IDX_W+4:0]  index_wide;

  // consume the held byte whenever the result queue has room
  assign take = held_valid && !queue_full;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= '0;
    end else if (cfg_wr_en) begin
      image_size <= cfg_wr_data;
    end
  end

  // helpers for the checks
  always_comb begin
    pos_cur     = held_word.start_req ? '0 : byte_position;
    shifted     = held_word.start_req ? {24'd0, held_word.data_byte}
                                      : {shift_word[23:0], held_word.data_byte};
    count_short = shifted[CNT_W-1:0];
    table_need  = SIZE_W'(HEADER_BYTES) + (SIZE_W'(count_short) << 4)
                + (SIZE_W'(count_short) << 2);
    span_end    = {1'b0, held_offset} + {1'b0, held_size};
    bad_bounds  = (SIZE_W'(held_offset) > image_size)
               || (SIZE_W'(held_size) > image_size)
               || (SIZE_W'(span_end) > image_size);
    final_entry = bad_bounds
               || ((CNT_W + 1)'(entry_index) + (CNT_W + 1)'(1)
                   >= (CNT_W + 1)'(slice_count));
    index_wide  = (IDX_W + 5)'(entry_index);
  end

  // per-byte decode
  always_comb begin
    phase_next         = phase;
    byte_position_next = byte_position;
    shift_word_next    = shift_word;
    slice_count_next   = slice_count;
    entry_index_next   = entry_index;
    held_cpu_type_next = held_cpu_type;
    held_subtype_next  = held_subtype;
    held_offset_next   = held_offset;
    held_size_next     = held_size;
    emit               = 1'b0;
    result             = '0;
    result.last        = 1'b1;

    if (take) begin
      if (held_word.start_req) begin
        byte_position_next = '0;
        slice_count_next   = '0;
        entry_index_next   = '0;
        shift_word_next    = '0;
      end

      if (held_word.start_req && (image_size < SIZE_W'(HEADER_BYTES))) begin
        // container cannot even hold the header
        emit          = 1'b1;
        result.status = ST_TOO_SMALL;
        phase_next    = PH_DONE;
      end else if (held_word.start_req || (phase == PH_HEADER)) begin
        shift_word_next = shifted;
        if ((pos_cur == POS_W'(3)) && (shifted != FAT_MAGIC)) begin
          emit          = 1'b1;
          result.status = ST_BAD_MAGIC;
          phase_next    = PH_DONE;
        end else if (pos_cur == POS_W'(7)) begin
          if ((shifted == 32'd0) || (shifted > 32'(MAX_SLICES))) begin
            emit          = 1'b1;
            result.status = ST_BAD_COUNT;
            phase_next    = PH_DONE;
          end else if (image_size < table_need) begin
            emit          = 1'b1;
            result.status = ST_TOO_SMALL;
            phase_next    = PH_DONE;
          end else begin
            slice_count_next   = count_short;
            entry_index_next   = '0;
            byte_position_next = '0;
            phase_next         = PH_TABLE;
          end
        end else begin
          byte_position_next = pos_cur + POS_W'(1);
          phase_next         = PH_HEADER;
        end
      end else if (phase == PH_TABLE) begin
        shift_word_next = shifted;
        case (byte_position)
          POS_W'(3):  held_cpu_type_next = shifted;
          POS_W'(7):  held_subtype_next  = shifted;
          POS_W'(11): held_offset_next   = shifted;
          POS_W'(15): held_size_next     = shifted;
          default: ;
        endcase
        if (byte_position < POS_W'(ENTRY_BYTES - 1)) begin
          byte_position_next = byte_position + POS_W'(1);
        end else begin
          // entry complete: report the slice
          emit                = 1'b1;
          result.status       = bad_bounds ? ST_OUT_OF_BOUND : ST_SLICE_OK;
          result.slice_index  = index_wide[4:0];
          result.cpu_type     = held_cpu_type;
          result.cpu_subtype  = held_subtype;
          result.slice_offset = held_offset;
          result.slice_size   = held_size;
          result.cpu_code     = cpu_code_of(held_cpu_type);
          result.is_64bit     = |(held_cpu_type & ABI64_BIT);
          result.last         = final_entry;
          byte_position_next  = '0;
          if (final_entry) begin
            phase_next = PH_DONE;
          end else begin
            entry_index_next = entry_index + IDX_W'(1);
          end
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
      slice_count   <= '0;
      entry_index   <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      slice_count   <= slice_count_next;
      entry_index   <= entry_index_next;
    end
  end

  // assembly word and entry fields
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_word    <= '0;
      held_cpu_type <= '0;
      held_subtype  <= '0;
      held_offset   <= '0;
      held_size     <= '0;
    end else begin
      shift_word    <= shift_word_next;
      held_cpu_type <= held_cpu_type_next;
      held_subtype  <= held_subtype_next;
      held_offset   <= held_offset_next;
      held_size     <= held_size_next;
    end
  end

endmodule

[rtl/fbhp_out_queue.sv]
// two-entry result queue in front of the output stream
`timescale 1ns / 1ps

module fbhp_out_queue
  import fbhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_word,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  result_t    slots [2];
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       pop;

  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_word  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

[rtl/fat_binary_header_parser_core.sv]
// top level of the fat binary header parser
`timescale 1ns / 1ps

// Parses a fat (universal) binary header fed as a byte stream, one byte per
// word, with tuser marking offset zero of a new container. One byte is taken
// every cycle; each byte passes through an input register and the decode
// against the parser state into a two-deep result queue, which drives the
// output. The input stalls only when two results are waiting in the queue.
// Results come on the last byte of each 20-byte table entry or on the first
// error, which ends the container (tlast high); bytes after that are dropped
// until the next start. The container byte size is written through
// cfg_wr_en/cfg_wr_data; the user must do so only while the stream is idle,
// as the block itself does not enforce this.
module fat_binary_header_parser_core
  import fbhp_pkg::*;
#(
  parameter int unsigned MAX_SLICES = 32
) (
  input  logic          clk,
  input  logic          rst,
  // configuration
  input  logic          cfg_wr_en,
  input  logic [39:0]   cfg_wr_data,    // image_size
  // byte stream in
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // data_byte
  input  logic          s_axis_tuser,   // start_req
  // results out
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata,   // slice_index, cpu_type, cpu_subtype,
                                        // slice_offset, slice_size, cpu_code,
                                        // is_64bit, zero fill
  output logic [2:0]    m_axis_tuser,   // status
  output logic          m_axis_tlast    // last
);

  in_word_t in_word;
  in_word_t held_word;
  logic     held_valid;
  logic     take;
  logic     emit;
  logic     queue_full;
  result_t  result;
  result_t  out_word;

  assign in_word.data_byte = s_axis_tdata;
  assign in_word.start_req = s_axis_tuser;

  // input register
  fbhp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_word    (in_word),
    .take       (take),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  // parser
  fbhp_parser #(
    .MAX_SLICES (MAX_SLICES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .held_valid  (held_valid),
    .held_word   (held_word),
    .queue_full  (queue_full),
    .take        (take),
    .emit        (emit),
    .result      (result)
  );

  // result queue
  fbhp_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_word (result),
    .full      (queue_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  // output packing
  assign m_axis_tdata = {6'd0, out_word.is_64bit, out_word.cpu_code,
                         out_word.slice_size, out_word.slice_offset,
                         out_word.cpu_subtype, out_word.cpu_type,
                         out_word.slice_index};
  assign m_axis_tuser = out_word.status;
  assign m_axis_tlast = out_word.last;

endmodule

[tb/fbhp_result_checker.sv]
// checker for the fat header parser: predicts results from accepted bytes and compares them
`timescale 1ns / 1ps

module fbhp_result_checker
  import fbhp_pkg::*;
#(
  parameter int unsigned MAX_SLICES = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [39:0]  cfg_wr_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [143:0] m_axis_tdata,
  input  logic [2:0]   m_axis_tuser,
  input  logic         m_axis_tlast,
  output int           mismatch_count,
  output int           pending_count,
  output int           results_checked,
  output int           slices_ok
);

  typedef enum logic [1:0] {
    PARSE_IDLE,
    PARSE_HEADER,
    PARSE_TABLE,
    PARSE_DONE
  } parse_phase_t;

  // shadow copy of the parser state and the size register
  logic [39:0]  size_reg = '0;
  parse_phase_t parse_phase = PARSE_IDLE;
  int unsigned  byte_pos = 0;
  logic [31:0]  assembly = '0;
  int unsigned  table_len = 0;
  int unsigned  entry_no = 0;
  logic [31:0]  held_type = '0;
  logic [31:0]  held_sub = '0;
  logic [31:0]  held_off = '0;
  logic [31:0]  held_len = '0;

  result_t predicted_results[$];
  int      errs = 0;
  int      checked = 0;
  int      good = 0;

  initial begin
    mismatch_count  = 0;
    pending_count   = 0;
    results_checked = 0;
    slices_ok       = 0;
  end

  // cpu type word to cpu code, 64-bit abi variants only for x86, arm and ppc
  function automatic logic [3:0] code_for_cpu(input logic [31:0] t);
    logic [3:0] c;
    logic       wide;
    c = CPU_UNKNOWN;
    wide = t[24];
    if (t[31:25] == 7'd0 && t[23:5] == 19'd0) begin
      case (t[4:0])
        5'd7:  c = wide ? CPU_X86_64 : CPU_X86;
        5'd12: c = wide ? CPU_ARM64 : CPU_ARM;
        5'd18: c = wide ? CPU_PPC64 : CPU_PPC;
        5'd6:  c = wide ? CPU_UNKNOWN : CPU_M68K;
        5'd13: c = wide ? CPU_UNKNOWN : CPU_M88K;
        5'd10: c = wide ? CPU_UNKNOWN : CPU_M98K;
        5'd14: c = wide ? CPU_UNKNOWN : CPU_SPARC;
        5'd8:  c = wide ? CPU_UNKNOWN : CPU_MIPS;
        5'd11: c = wide ? CPU_UNKNOWN : CPU_HPPA;
        5'd15: c = wide ? CPU_UNKNOWN : CPU_I860;
        5'd1:  c = wide ? CPU_UNKNOWN : CPU_VAX;
        default: c = CPU_UNKNOWN;
      endcase
    end
    return c;
  endfunction

  // header errors carry only the status and last
  function automatic result_t header_fault(input status_t s);
    result_t r;
    r = '0;
    r.status = s;
    r.last = 1'b1;
    return r;
  endfunction

  task automatic reset_parser();
    parse_phase = PARSE_IDLE;
    byte_pos = 0;
    assembly = '0;
    table_len = 0;
    entry_no = 0;
    held_type = '0;
    held_sub = '0;
    held_off = '0;
    held_len = '0;
  endtask

  // consume one byte, report whether it closes a result
  task automatic advance_parser(input logic [7:0] b, input logic st,
                                output bit produced, output result_t res);
    logic [63:0] table_need;
    logic [63:0] span_end;
    bit          oob;
    bit          fin;
    produced = 1'b0;
    res = '0;
    if (st) begin
      reset_parser();
      parse_phase = PARSE_HEADER;
      if (size_reg < 40'(HEADER_BYTES)) begin
        res = header_fault(ST_TOO_SMALL);
        parse_phase = PARSE_DONE;
        produced = 1'b1;
        return;
      end
    end else if (parse_phase != PARSE_HEADER && parse_phase != PARSE_TABLE) begin
      return;
    end

    assembly = {assembly[23:0], b};

    // header: magic then slice count
    if (parse_phase == PARSE_HEADER) begin
      if (byte_pos == 3 && assembly != FAT_MAGIC) begin
        res = header_fault(ST_BAD_MAGIC);
        parse_phase = PARSE_DONE;
        produced = 1'b1;
        return;
      end
      if (byte_pos == 7) begin
        table_need = 64'(HEADER_BYTES) + 64'(assembly) * 64'(ENTRY_BYTES);
        if (assembly == 32'd0 || assembly > 32'(MAX_SLICES)) begin
          res = header_fault(ST_BAD_COUNT);
          parse_phase = PARSE_DONE;
          produced = 1'b1;
        end else if (64'(size_reg) < table_need) begin
          res = header_fault(ST_TOO_SMALL);
          parse_phase = PARSE_DONE;
          produced = 1'b1;
        end else begin
          table_len = assembly;
          entry_no = 0;
          byte_pos = 0;
          parse_phase = PARSE_TABLE;
        end
        return;
      end
      byte_pos++;
      return;
    end

    // table entry: four big-endian words, the fifth is skipped
    case (byte_pos)
      3:  held_type = assembly;
      7:  held_sub = assembly;
      11: held_off = assembly;
      15: held_len = assembly;
      default: ;
    endcase
    if (byte_pos + 1 < ENTRY_BYTES) begin
      byte_pos++;
      return;
    end

    span_end = 64'(held_off) + 64'(held_len);
    oob = (40'(held_off) > size_reg) || (40'(held_len) > size_reg) ||
          (span_end > 64'(size_reg));
    fin = oob || (entry_no + 1 >= table_len);
    res.status = oob ? ST_OUT_OF_BOUND : ST_SLICE_OK;
    res.slice_index = entry_no[4:0];
    res.cpu_type = held_type;
    res.cpu_subtype = held_sub;
    res.slice_offset = held_off;
    res.slice_size = held_len;
    res.cpu_code = code_for_cpu(held_type);
    res.is_64bit = held_type[24];
    res.last = fin;
    produced = 1'b1;
    byte_pos = 0;
    if (fin)
      parse_phase = PARSE_DONE;
    else
      entry_no++;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errs++;
      if (errs <= 40)
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // tdata layout from bit 0: slice_index, cpu_type, cpu_subtype, slice_offset,
  // slice_size, cpu_code, is_64bit, zero fill
  task automatic compare_result(input result_t want);
    check_field("status", 32'(want.status), 32'(m_axis_tuser));
    check_field("slice_index", 32'(want.slice_index), 32'(m_axis_tdata[4:0]));
    check_field("cpu_type", want.cpu_type, m_axis_tdata[36:5]);
    check_field("cpu_subtype", want.cpu_subtype, m_axis_tdata[68:37]);
    check_field("slice_offset", want.slice_offset, m_axis_tdata[100:69]);
    check_field("slice_size", want.slice_size, m_axis_tdata[132:101]);
    check_field("cpu_code", 32'(want.cpu_code), 32'(m_axis_tdata[136:133]));
    check_field("is_64bit", 32'(want.is_64bit), 32'(m_axis_tdata[137]));
    check_field("zero fill", 32'd0, 32'(m_axis_tdata[143:138]));
    check_field("last", 32'(want.last), 32'(m_axis_tlast));
  endtask

  // watch both channels and the register port at each edge
  always @(posedge clk) begin : watch
    bit      produced;
    result_t fresh;
    result_t want;
    if (rst) begin
      reset_parser();
      size_reg = '0;
      predicted_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_parser(s_axis_tdata, s_axis_tuser, produced, fresh);
        if (produced)
          predicted_results.push_back(fresh);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_results.size() == 0) begin
          errs++;
          if (errs <= 40)
            $display("%0t: result word with none expected, expected none actual %h/%h",
                     $time, m_axis_tuser, m_axis_tdata);
        end else begin
          want = predicted_results.pop_front();
          compare_result(want);
          checked++;
          if (want.status == ST_SLICE_OK)
            good++;
        end
      end
      if (cfg_wr_en)
        size_reg = cfg_wr_data;
    end
    mismatch_count  <= errs;
    pending_count   <= predicted_results.size();
    results_checked <= checked;
    slices_ok       <= good;
  end

endmodule

[tb/tb_fat_binary_header_parser_core.sv]
// top of the fat header parser testbench: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps

module tb_fat_binary_header_parser_core;
  import fbhp_pkg::*;

  localparam int unsigned MAX_SLICES = 32;
  localparam int QUIET_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BYTES = 80;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_MOSTLY,
    SINK_SPARSE,
    SINK_PERIODIC
  } sink_mode_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         cfg_wr_en = 1'b0;
  logic [39:0]  cfg_wr_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;    // data_byte
  logic         s_axis_tuser = 1'b0;  // start_req
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;         // slice_index, cpu_type, cpu_subtype, slice_offset,
                                      // slice_size, cpu_code, is_64bit, zero fill
  logic [2:0]   m_axis_tuser;         // status
  logic         m_axis_tlast;         // last

  int mismatch_count;
  int pending_count;
  int results_checked;
  int slices_ok;

  logic [39:0] cur_size = '0;
  logic [7:0]  frame_q[$];
  int          burst_left = 0;
  int          parsed_bytes = 0;
  int          containers = 0;
  int          settings = 0;
  int          quiet_cycles = 0;
  sink_mode_t  sink_mode = SINK_OPEN;
  int          sink_ticks = 0;

  fat_binary_header_parser_core #(
    .MAX_SLICES(MAX_SLICES)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  fbhp_result_checker #(
    .MAX_SLICES(MAX_SLICES)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .mismatch_count(mismatch_count),
    .pending_count(pending_count),
    .results_checked(results_checked),
    .slices_ok(slices_ok)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: the ready pattern mode is redrawn at random whenever the tick counter runs out
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_ticks <= 0;
      sink_mode <= SINK_OPEN;
    end else begin
      if (sink_ticks == 0) begin
        sink_ticks <= 47;
        sink_mode <= sink_mode_t'($urandom_range(0, 3));
      end else begin
        sink_ticks <= sink_ticks - 1;
      end
      case (sink_mode)
        SINK_OPEN:   m_axis_tready <= 1'b1;
        SINK_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
        SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default:     m_axis_tready <= (sink_ticks % 5 < 2);
      endcase
    end
  end

  // watchdog on cycles with no word moved and no register write
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without progress", quiet_cycles);
        $display("[fat_binary_header_parser_core] ERROR");
        $finish;
      end
    end
  end

  // one byte, sent in bursts with random gaps
  task automatic put_byte(input logic [7:0] b, input logic st);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= st;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // hold the stream until every predicted result has come out
  task automatic wait_results_clear();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic set_container_size(input logic [39:0] v);
    wait_results_clear();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_size = v;
    settings++;
  endtask

  task automatic push_word(input logic [31:0] w);
    frame_q.push_back(w[31:24]);
    frame_q.push_back(w[23:16]);
    frame_q.push_back(w[15:8]);
    frame_q.push_back(w[7:0]);
  endtask

  task automatic set_word_at(input int idx, input logic [31:0] w);
    frame_q[idx]     = w[31:24];
    frame_q[idx + 1] = w[23:16];
    frame_q[idx + 2] = w[15:8];
    frame_q[idx + 3] = w[7:0];
  endtask

  // send the first len bytes of the frame, start on the first
  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) begin
      put_byte(frame_q[i], i == 0);
      parsed_bytes++;
    end
  endtask

  function automatic logic [31:0] pick_cpu();
    logic [31:0] t;
    case ($urandom_range(0, 18))
      0:  t = 32'd7;
      1:  t = 32'd7 | ABI64_BIT;
      2:  t = 32'd12;
      3:  t = 32'd12 | ABI64_BIT;
      4:  t = 32'd18;
      5:  t = 32'd18 | ABI64_BIT;
      6:  t = 32'd6;
      7:  t = 32'd13;
      8:  t = 32'd10;
      9:  t = 32'd14;
      10: t = 32'd8;
      11: t = 32'd11;
      12: t = 32'd15;
      13: t = 32'd1;
      14: t = 32'd6 | ABI64_BIT;
      15: t = 32'd0;
      default: t = $urandom;
    endcase
    return t;
  endfunction

  // offset and size: in bounds, on the edge, just over, or anywhere
  task automatic pick_span(output logic [31:0] off, output logic [31:0] sz);
    logic [31:0] cap;
    int          mode;
    cap = (cur_size > 40'hFFFF_FFFF) ? 32'hFFFF_FFFF : cur_size[31:0];
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      off = $urandom_range(cap, 0);
      sz = $urandom_range(cap - off, 0);
    end else if (mode == 6) begin
      off = $urandom_range(cap, 0);
      sz = cap - off;
    end else if (mode == 7) begin
      if (cur_size < 40'hFFFF_FFFF) begin
        off = $urandom_range(cur_size[31:0], 0);
        sz = cur_size[31:0] - off + 32'd1;
      end else begin
        off = '1;
        sz = '1;
      end
    end else if (mode == 8 && cur_size < 40'hFFFF_FFFF) begin
      if ($urandom_range(0, 1) == 0) begin
        off = cur_size[31:0] + 32'd1;
        sz = 32'd0;
      end else begin
        off = 32'd0;
        sz = cur_size[31:0] + 32'd1;
      end
    end else begin
      off = $urandom;
      sz = $urandom;
    end
  endtask

  // well-formed container with n table entries
  task automatic build_container(input int n);
    logic [31:0] off;
    logic [31:0] sz;
    frame_q.delete();
    push_word(FAT_MAGIC);
    push_word(32'(n));
    for (int i = 0; i < n; i++) begin
      push_word(pick_cpu());
      push_word($urandom);
      pick_span(off, sz);
      push_word(off);
      push_word(sz);
      push_word($urandom);
    end
  endtask

  // one container of a random kind: good, broken header, cut short, noise or junk
  task automatic send_one_container(input bit full_table);
    int          kind;
    int          n;
    logic [31:0] w;
    kind = $urandom_range(0, 99);
    if (full_table)
      n = MAX_SLICES;
    else if ($urandom_range(0, 19) == 0)
      n = $urandom_range(4, MAX_SLICES);
    else
      n = $urandom_range(1, 3);
    build_container(n);
    if (full_table || kind < 55) begin
      send_frame(frame_q.size());
    end else if (kind < 65) begin
      if ($urandom_range(0, 1) == 0)
        w = FAT_MAGIC ^ (32'd1 << $urandom_range(0, 31));
      else
        w = $urandom;
      set_word_at(0, w);
      send_frame(4 + $urandom_range(0, 6));
    end else if (kind < 75) begin
      case ($urandom_range(0, 3))
        0: w = 32'd0;
        1: w = MAX_SLICES + 1;
        2: w = $urandom_range(32'hFFFF_FFFF, MAX_SLICES + 2);
        default: w = 32'hFFFF_FFFF;
      endcase
      set_word_at(4, w);
      send_frame(8 + $urandom_range(0, 4));
    end else if (kind < 88) begin
      send_frame($urandom_range(1, frame_q.size() - 1));
    end else if (kind < 95) begin
      // bytes without a start: dropped unless a container is still open
      repeat ($urandom_range(1, 6)) put_byte($urandom, 1'b0);
      return;
    end else begin
      for (int i = 0; i < 12; i++)
        frame_q[i] = $urandom;
      send_frame($urandom_range(1, 12));
    end
    containers++;
  endtask

  initial begin : stimulus
    logic [39:0] size_plan[8];
    int          mark;
    size_plan[0] = 40'hFF_FFFF_FFFF;
    size_plan[1] = 40'd8;
    size_plan[2] = 40'd28;
    size_plan[3] = 40'd68;
    size_plan[4] = 40'h1_0000_0000;
    size_plan[5] = {8'($urandom_range(0, 255)), 32'($urandom)};
    size_plan[6] = 40'($urandom_range(100, 2000));
    size_plan[7] = 40'hFFFF_FFFF;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // tiny containers: the start byte alone fails
    set_container_size(40'd0);
    put_byte(8'hCA, 1'b1);
    set_container_size(40'd7);
    put_byte(8'hCA, 1'b1);

    // broken magic, zero count, count one past the limit
    set_container_size(40'hFF_FFFF_FFFF);
    frame_q.delete();
    push_word(FAT_MAGIC ^ 32'd1);
    send_frame(4);
    frame_q.delete();
    push_word(FAT_MAGIC);
    push_word(32'd0);
    send_frame(8);
    set_word_at(4, MAX_SLICES + 1);
    send_frame(8);
    containers += 5;

    // random containers under each size setting
    for (int ph = 0; ph < 8; ph++) begin
      set_container_size(size_plan[ph]);
      mark = parsed_bytes;
      send_one_container(ph == 0);
      while (parsed_bytes - mark < PHASE_BYTES) begin
        send_one_container(1'b0);
        if ($urandom_range(0, 19) == 0)
          wait_results_clear();
      end
    end

    wait_results_clear();
    $display("covered %0d containers over %0d size settings, %0d bytes sent",
             containers, settings, parsed_bytes);
    $display("checked %0d result words, %0d of them good slices", results_checked, slices_ok);
    if (mismatch_count == 0 && pending_count == 0)
      $display("[fat_binary_header_parser_core] OK");
    else
      $display("[fat_binary_header_parser_core] ERROR");
    $finish;
  end

endmodule
